// File: hdl/mma_pkg.sv
// Package: shared types, codes and reset values of the Montgomery modular ALU
`timescale 1ns / 1ps

package mma_pkg;

	localparam logic [29:0] MODULUS_RST = 30'd998244353;
	localparam logic [31:0] MINV_RST    = 32'd3296722945;
	localparam logic [29:0] R2_RST      = 30'd932051910;

	localparam int unsigned DIV_CNT_W = 6;

	typedef enum logic [3:0] {
		OP_FROM_INT = 4'd0,
		OP_ADD      = 4'd1,
		OP_SUB      = 4'd2,
		OP_MUL      = 4'd3,
		OP_POW      = 4'd4,
		OP_INV      = 4'd5,
		OP_CANON    = 4'd6,
		OP_EQUAL    = 4'd7,
		OP_NEGATE   = 4'd8,
		OP_DIVIDE   = 4'd9
	} op_t;

	typedef enum logic [1:0] {
		REG_MODULUS = 2'd0,
		REG_MINV    = 2'd1,
		REG_R2      = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_DIV,
		ST_DIV_END,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_MUL4,
		ST_POW_BIT,
		ST_FIN
	} state_t;

	typedef enum logic [2:0] {
		SEL_A_B,
		SEL_A_ONE,
		SEL_T_R2,
		SEL_ACC_SQ,
		SEL_SQ_SQ,
		SEL_ACC_A
	} sel_t;

	typedef enum logic [2:0] {
		JOB_RES,
		JOB_RES_NORM,
		JOB_ACC_INIT,
		JOB_ACC,
		JOB_SQ
	} job_t;

	typedef struct packed {
		logic [29:0] modulus;
		logic [31:0] modulus_inverse;
		logic [29:0] r_squared;
	} cfg_t;

	typedef struct packed {
		logic load_in;
		logic simple;
		logic div_init;
		logic div_step;
		logic t_load;
		logic pow_init;
		logic mul_start;
		sel_t mul_sel;
		logic mul_write;
		job_t mul_job;
		logic acc_to_res;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic [3:0] op;
		logic       div_last;
		logic       e_zero;
		logic       e_lsb;
	} status_t;

endpackage

// File: hdl/mma_req_if.sv
// Interface: request channel carrying one operation item
`timescale 1ns / 1ps

interface mma_req_if;
	logic               valid;
	logic               ready;
	logic [3:0]         op;
	logic [30:0]        operand_a;
	logic [30:0]        operand_b;
	logic signed [63:0] integer_in;
	logic [63:0]        exponent;

	modport source (
		output valid, op, operand_a, operand_b, integer_in, exponent,
		input  ready
	);
	modport sink (
		input  valid, op, operand_a, operand_b, integer_in, exponent,
		output ready
	);
endinterface

// File: hdl/mma_rsp_if.sv
// Interface: response channel carrying one result item
`timescale 1ns / 1ps

interface mma_rsp_if;
	logic        valid;
	logic        ready;
	logic [30:0] result;
	logic        is_equal;

	modport source (
		output valid, result, is_equal,
		input  ready
	);
	modport sink (
		input  valid, result, is_equal,
		output ready
	);
endinterface

// File: hdl/montgomery_modular_alu_core.sv
// Top level: Montgomery modular ALU with APB register port, controller and datapath
// One request item gives one response item. Add, subtract, negate, equality and unknown
// codes are registered from combinational logic; multiply and canonical conversion use one
// Montgomery multiplication; conversion from a signed integer runs the one-bit-per-cycle
// remainder divider, then one Montgomery multiplication. Power, inverse and divide run on
// the single shared Montgomery multiplier, whose reduction steps through states MUL1 to
// MUL4; each runs a setup, then per exponent bit up to its highest set bit a squaring,
// preceded by a multiply into the accumulator where the bit is set, then the finish (a
// multiplication by operand a for divide). Inverse and divide use the exponent modulus - 2,
// wrapped to 32 bits. A new item is accepted while the previous result waits in the output register.
`timescale 1ns / 1ps

module montgomery_modular_alu_core (
	input  logic        clk,
	input  logic        arst_n,
	mma_req_if.sink     req,
	mma_rsp_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	mma_pkg::cfg_t    cfg_q;
	mma_pkg::cmd_t    cmd;
	mma_pkg::status_t st;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.modulus         <= mma_pkg::MODULUS_RST;
			cfg_q.modulus_inverse <= mma_pkg::MINV_RST;
			cfg_q.r_squared       <= mma_pkg::R2_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				mma_pkg::REG_MODULUS: cfg_q.modulus         <= pwdata[29:0];
				mma_pkg::REG_MINV:    cfg_q.modulus_inverse <= pwdata;
				mma_pkg::REG_R2:      cfg_q.r_squared       <= pwdata[29:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			mma_pkg::REG_MODULUS: prdata = {2'b00, cfg_q.modulus};
			mma_pkg::REG_MINV:    prdata = cfg_q.modulus_inverse;
			mma_pkg::REG_R2:      prdata = {2'b00, cfg_q.r_squared};
			default:              prdata = 32'd0;
		endcase
	end

	mma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.st        (st),
		.cmd       (cmd)
	);

	mma_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cmd        (cmd),
		.st         (st),
		.op         (req.op),
		.operand_a  (req.operand_a),
		.operand_b  (req.operand_b),
		.integer_in (req.integer_in),
		.exponent   (req.exponent),
		.result     (rsp.result),
		.is_equal   (rsp.is_equal)
	);

endmodule

// File: hdl/mma_datapath.sv
// Datapath: operand registers, remainder divider, Montgomery multiplier and output register
`timescale 1ns / 1ps

module mma_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  mma_pkg::cfg_t      cfg,
	input  mma_pkg::cmd_t      cmd,
	output mma_pkg::status_t   st,
	input  logic [3:0]         op,
	input  logic [30:0]        operand_a,
	input  logic [30:0]        operand_b,
	input  logic signed [63:0] integer_in,
	input  logic [63:0]        exponent,
	output logic [30:0]        result,
	output logic               is_equal
);

	logic [3:0]  op_q;
	logic [30:0] a_q;
	logic [30:0] b_q;
	logic [63:0] int_q;
	logic [63:0] exp_q;

	logic [63:0] mag_q;
	logic [30:0] rem_q;
	logic        neg_q;
	logic [mma_pkg::DIV_CNT_W-1:0] cnt_q;

	logic [30:0] t_q;
	logic [31:0] acc_q;
	logic [31:0] sq_q;
	logic [31:0] res_q;
	logic        eq_q;
	logic [63:0] e_q;

	logic [63:0] p_s1;
	logic [31:0] q_s2;
	logic [31:0] c_s3;

	logic [30:0] result_q;
	logic        is_equal_q;

	logic [31:0] m32;
	logic [31:0] twice;
	logic [31:0] a32;
	logic [31:0] b32;
	logic [30:0] rem_shift;
	logic [30:0] rem_next;
	logic [30:0] rem_eff;
	logic [30:0] t_from_rem;
	logic [30:0] t_one;
	logic [31:0] mx;
	logic [31:0] my;
	logic [63:0] prod;
	logic [63:0] qfull;
	logic [63:0] cfull;
	logic [31:0] red;
	logic [31:0] red_norm;
	logic [31:0] add_x;
	logic [31:0] add_r;
	logic [31:0] sub_x;
	logic [31:0] sub_r;
	logic [31:0] neg_x;
	logic [31:0] neg_r;
	logic [31:0] norm_a;
	logic [31:0] norm_b;
	logic [31:0] simple_res;
	logic        simple_eq;

	assign m32   = {2'b00, cfg.modulus};
	assign twice = {1'b0, cfg.modulus, 1'b0};
	assign a32   = {1'b0, a_q};
	assign b32   = {1'b0, b_q};

	assign rem_shift  = {rem_q[29:0], mag_q[63]};
	assign rem_next   = (rem_shift >= {1'b0, cfg.modulus}) ?
		rem_shift - {1'b0, cfg.modulus} : rem_shift;
	assign rem_eff    = (cfg.modulus == 30'd0) ? 31'd0 : rem_q;
	assign t_from_rem = neg_q ? {1'b0, cfg.modulus} - rem_eff : {1'b0, cfg.modulus} + rem_eff;
	assign t_one      = {1'b0, cfg.modulus} + {30'd0, (cfg.modulus > 30'd1)};

	always_comb begin
		case (cmd.mul_sel)
			mma_pkg::SEL_A_B: begin
				mx = a32;
				my = b32;
			end
			mma_pkg::SEL_A_ONE: begin
				mx = a32;
				my = 32'd1;
			end
			mma_pkg::SEL_T_R2: begin
				mx = {1'b0, t_q};
				my = {2'b00, cfg.r_squared};
			end
			mma_pkg::SEL_ACC_SQ: begin
				mx = acc_q;
				my = sq_q;
			end
			mma_pkg::SEL_SQ_SQ: begin
				mx = sq_q;
				my = sq_q;
			end
			mma_pkg::SEL_ACC_A: begin
				mx = a32;
				my = acc_q;
			end
			default: begin
				mx = a32;
				my = b32;
			end
		endcase
	end

	assign prod     = 64'(mx) * 64'(my);
	assign qfull    = 64'(p_s1[31:0]) * 64'(cfg.modulus_inverse);
	assign cfull    = 64'(q_s2) * 64'(m32);
	assign red      = p_s1[63:32] + m32 - c_s3;
	assign red_norm = (red >= m32) ? red - m32 : red;

	assign add_x  = a32 + (b32 - twice);
	assign add_r  = add_x[31] ? add_x + twice : add_x;
	assign sub_x  = a32 - b32;
	assign sub_r  = sub_x[31] ? sub_x + twice : sub_x;
	assign neg_x  = 32'd0 - a32;
	assign neg_r  = neg_x[31] ? neg_x + twice : neg_x;
	assign norm_a = (a32 >= m32) ? a32 - m32 : a32;
	assign norm_b = (b32 >= m32) ? b32 - m32 : b32;

	always_comb begin
		simple_res = 32'd0;
		simple_eq  = 1'b0;
		case (op_q)
			mma_pkg::OP_ADD:    simple_res = add_r;
			mma_pkg::OP_SUB:    simple_res = sub_r;
			mma_pkg::OP_NEGATE: simple_res = neg_r;
			mma_pkg::OP_EQUAL:  simple_eq  = (norm_a == norm_b);
			default:            simple_res = 32'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q  <= op;
			a_q   <= operand_a;
			b_q   <= operand_b;
			int_q <= $unsigned(integer_in);
			exp_q <= exponent;
			eq_q  <= 1'b0;
		end
		if (cmd.div_init) begin
			neg_q <= int_q[63];
			mag_q <= int_q[63] ? 64'd0 - int_q : int_q;
			rem_q <= 31'd0;
		end
		if (cmd.div_step) begin
			rem_q <= rem_next;
			mag_q <= {mag_q[62:0], 1'b0};
		end
		if (cmd.t_load) begin
			t_q <= t_from_rem;
		end
		if (cmd.pow_init) begin
			t_q  <= t_one;
			sq_q <= (op_q == mma_pkg::OP_DIVIDE) ? b32 : a32;
			e_q  <= (op_q == mma_pkg::OP_POW) ? exp_q : {32'd0, m32 - 32'd2};
		end
		if (cmd.simple) begin
			res_q <= simple_res;
			eq_q  <= simple_eq;
		end
		if (cmd.mul_start) begin
			p_s1 <= prod;
		end
		q_s2 <= qfull[31:0];
		c_s3 <= cfull[63:32];
		if (cmd.mul_write) begin
			case (cmd.mul_job)
				mma_pkg::JOB_RES:      res_q <= red;
				mma_pkg::JOB_RES_NORM: res_q <= red_norm;
				mma_pkg::JOB_ACC_INIT: acc_q <= red;
				mma_pkg::JOB_ACC:      acc_q <= red;
				mma_pkg::JOB_SQ: begin
					sq_q <= red;
					e_q  <= {1'b0, e_q[63:1]};
				end
				default: res_q <= red;
			endcase
		end
		if (cmd.acc_to_res) begin
			res_q <= acc_q;
		end
		if (cmd.load_out) begin
			result_q   <= res_q[30:0];
			is_equal_q <= eq_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_init) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign st.op       = op_q;
	assign st.div_last = (cnt_q == {mma_pkg::DIV_CNT_W{1'b1}});
	assign st.e_zero   = (e_q == 64'd0);
	assign st.e_lsb    = e_q[0];

	assign result   = result_q;
	assign is_equal = is_equal_q;

endmodule

// File: hdl/mma_ctrl.sv
// Controller: state machine sequencing the divider, multiplier steps and power loop
`timescale 1ns / 1ps

module mma_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  mma_pkg::status_t st,
	output mma_pkg::cmd_t    cmd
);

	mma_pkg::state_t state_q;
	mma_pkg::state_t state_d;
	mma_pkg::sel_t   sel_q;
	mma_pkg::sel_t   sel_d;
	mma_pkg::job_t   job_q;
	mma_pkg::job_t   job_d;
	logic            out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mma_pkg::ST_IDLE;
			sel_q       <= mma_pkg::SEL_A_B;
			job_q       <= mma_pkg::JOB_RES;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			job_q   <= job_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		sel_d    = sel_q;
		job_d    = job_q;
		in_ready = 1'b0;
		case (state_q)
			mma_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = mma_pkg::ST_DISPATCH;
				end
			end
			mma_pkg::ST_DISPATCH: begin
				case (st.op)
					mma_pkg::OP_FROM_INT: begin
						cmd.div_init = 1'b1;
						state_d      = mma_pkg::ST_DIV;
					end
					mma_pkg::OP_MUL: begin
						sel_d   = mma_pkg::SEL_A_B;
						job_d   = mma_pkg::JOB_RES;
						state_d = mma_pkg::ST_MUL1;
					end
					mma_pkg::OP_CANON: begin
						sel_d   = mma_pkg::SEL_A_ONE;
						job_d   = mma_pkg::JOB_RES_NORM;
						state_d = mma_pkg::ST_MUL1;
					end
					mma_pkg::OP_POW, mma_pkg::OP_INV, mma_pkg::OP_DIVIDE: begin
						cmd.pow_init = 1'b1;
						sel_d        = mma_pkg::SEL_T_R2;
						job_d        = mma_pkg::JOB_ACC_INIT;
						state_d      = mma_pkg::ST_MUL1;
					end
					default: begin
						cmd.simple = 1'b1;
						state_d    = mma_pkg::ST_FIN;
					end
				endcase
			end
			mma_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last) begin
					state_d = mma_pkg::ST_DIV_END;
				end
			end
			mma_pkg::ST_DIV_END: begin
				cmd.t_load = 1'b1;
				sel_d      = mma_pkg::SEL_T_R2;
				job_d      = mma_pkg::JOB_RES;
				state_d    = mma_pkg::ST_MUL1;
			end
			mma_pkg::ST_MUL1: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = sel_q;
				state_d       = mma_pkg::ST_MUL2;
			end
			mma_pkg::ST_MUL2: begin
				state_d = mma_pkg::ST_MUL3;
			end
			mma_pkg::ST_MUL3: begin
				state_d = mma_pkg::ST_MUL4;
			end
			mma_pkg::ST_MUL4: begin
				cmd.mul_write = 1'b1;
				cmd.mul_job   = job_q;
				case (job_q)
					mma_pkg::JOB_ACC_INIT: state_d = mma_pkg::ST_POW_BIT;
					mma_pkg::JOB_SQ:       state_d = mma_pkg::ST_POW_BIT;
					mma_pkg::JOB_ACC: begin
						sel_d   = mma_pkg::SEL_SQ_SQ;
						job_d   = mma_pkg::JOB_SQ;
						state_d = mma_pkg::ST_MUL1;
					end
					default: state_d = mma_pkg::ST_FIN;
				endcase
			end
			mma_pkg::ST_POW_BIT: begin
				if (st.e_zero) begin
					if (st.op == mma_pkg::OP_DIVIDE) begin
						sel_d   = mma_pkg::SEL_ACC_A;
						job_d   = mma_pkg::JOB_RES;
						state_d = mma_pkg::ST_MUL1;
					end else begin
						cmd.acc_to_res = 1'b1;
						state_d        = mma_pkg::ST_FIN;
					end
				end else if (st.e_lsb) begin
					sel_d   = mma_pkg::SEL_ACC_SQ;
					job_d   = mma_pkg::JOB_ACC;
					state_d = mma_pkg::ST_MUL1;
				end else begin
					sel_d   = mma_pkg::SEL_SQ_SQ;
					job_d   = mma_pkg::JOB_SQ;
					state_d = mma_pkg::ST_MUL1;
				end
			end
			mma_pkg::ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = mma_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mma_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// File: hdl/mma_checker.sv
// Checker: port-level assertions for the Montgomery modular ALU, bound to the top level
`timescale 1ns / 1ps

module mma_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [30:0] rsp_result,
	input logic        rsp_is_equal
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response item dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_result) && $stable(rsp_is_equal))
		else $error("response item changed while stalled");

	a_eq_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_is_equal |-> rsp_result == 31'd0)
		else $error("equality item carries a non-zero result");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken again before the previous item was processed");

endmodule

bind montgomery_modular_alu_core mma_checker u_mma_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_result   (rsp.result),
	.rsp_is_equal (rsp.is_equal)
);
